FILE: rtl/core/assert_macros.svh
// Assertion macros shared by the sorted priority queue RTL.
// Depends on nothing; included by the files that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every clock edge outside reset.
`define SPQ_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked on every clock edge, reset included.
`define SPQ_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: rtl/core/spq_pkg.sv
// Types and constants of the sorted priority queue.
// Depends on nothing; used by the controller, the datapath and the top level.
`timescale 1ns / 1ps

package spq_pkg;

   localparam int VALUE_W  = 16;
   localparam int PRIO_W   = 8;
   localparam int STATUS_W = 2;
   localparam int OCC_W    = 5;
   localparam int CAP_W    = 5;

   localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

   localparam logic OP_ENQUEUE = 1'b0;
   localparam logic OP_DEQUEUE = 1'b1;

   localparam logic [STATUS_W-1:0] STAT_DONE  = 2'd0;
   localparam logic [STATUS_W-1:0] STAT_FULL  = 2'd1;
   localparam logic [STATUS_W-1:0] STAT_EMPTY = 2'd2;

   typedef struct packed {
      logic                capture;
      logic                execute;
      logic                insert;
      logic                remove;
      logic [STATUS_W-1:0] status;
   } cmd_type;

   typedef struct packed {
      logic op;
      logic full;
      logic empty;
   } stat_type;

endpackage

FILE: rtl/core/spq_ctrl.sv
// Controller of the sorted priority queue: capture and execute sequencing.
// Depends on spq_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module spq_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   output logic              rsp_strobe,
   output spq_pkg::cmd_type  cmd,
   input  spq_pkg::stat_type stat
);
   import spq_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_EXEC = 2'b10
   } state_type;

   state_type state_ff;
   state_type state_in;
   logic      strobe_ff;
   logic      strobe_in;

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd.capture = 1'b1;
               state_in    = ST_EXEC;
            end
         end
         ST_EXEC: begin
            cmd.execute = 1'b1;
            state_in    = ST_IDLE;
            priority if (stat.op == OP_DEQUEUE) begin
               if (stat.empty) begin
                  cmd.status = STAT_EMPTY;
               end else begin
                  cmd.remove = 1'b1;
                  cmd.status = STAT_DONE;
               end
            end else begin
               if (stat.full) begin
                  cmd.status = STAT_FULL;
               end else begin
                  cmd.insert = 1'b1;
                  cmd.status = STAT_DONE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign strobe_in  = cmd.execute;
   assign busy       = (state_ff == ST_EXEC);
   assign rsp_strobe = strobe_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         strobe_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         strobe_ff <= strobe_in;
      end
   end

   `SPQ_ASSERT(a_capture_then_busy, clock, reset, cmd.capture |=> busy, "capture not followed by execute")
   `SPQ_ASSERT_ALWAYS(a_single_action, clock, !(cmd.insert && cmd.remove), "insert and remove together")
   `SPQ_ASSERT(a_strobe_when_idle, clock, reset, rsp_strobe |-> !busy, "result shown while busy")

endmodule

FILE: rtl/core/spq_datapath.sv
// Datapath of the sorted priority queue: request registers, a row of
// compare-and-shift entry cells, the count, capacity and result registers.
// Depends on spq_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module spq_datapath #(
   parameter int DEPTH = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_we,
   input  logic [spq_pkg::CAP_W-1:0]     csr_wdata,
   input  logic                          req_op,
   input  logic [spq_pkg::VALUE_W-1:0]   req_item_value,
   input  logic [spq_pkg::PRIO_W-1:0]    req_priority_req,
   input  spq_pkg::cmd_type              cmd,
   output spq_pkg::stat_type             stat,
   output logic [spq_pkg::STATUS_W-1:0]  rsp_status,
   output logic [spq_pkg::VALUE_W-1:0]   rsp_removed_value,
   output logic [spq_pkg::OCC_W-1:0]     rsp_occupancy
);
   import spq_pkg::*;

   localparam int CW = $clog2(DEPTH + 1);
   localparam int MW = (CW > CAP_W) ? CW : CAP_W;

   logic                op_ff;
   logic [VALUE_W-1:0]  item_ff;
   logic [PRIO_W-1:0]   prio_ff;
   logic [CAP_W-1:0]    capacity_ff;
   logic [CW-1:0]       held_ff;
   logic [CW-1:0]       held_in;
   logic [MW-1:0]       occ_wide;
   logic [STATUS_W-1:0] status_ff;
   logic [VALUE_W-1:0]  removed_ff;
   logic [VALUE_W-1:0]  removed_in;
   logic [OCC_W-1:0]    occ_ff;

   logic [VALUE_W-1:0]  val_ff  [DEPTH];
   logic [PRIO_W-1:0]   pri_ff  [DEPTH];
   logic [VALUE_W-1:0]  val_in  [DEPTH];
   logic [PRIO_W-1:0]   pri_in  [DEPTH];
   logic [DEPTH-1:0]    lt;

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff   <= req_op;
         item_ff <= req_item_value;
         prio_ff <= req_priority_req;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff <= CAP_RESET;
      end else if (csr_we) begin
         capacity_ff <= csr_wdata;
      end
   end

   assign stat.op    = op_ff;
   assign stat.empty = (held_ff == '0);
   assign stat.full  = (MW'(held_ff) >= MW'(capacity_ff)) || (MW'(held_ff) >= MW'(DEPTH));

   // On insert, each cell decides from its own and its upper neighbor's comparison
   // whether it keeps its entry, takes the new one or takes the shifted one.
   for (genvar k = 0; k < DEPTH; k++) begin : g_cell
      logic                prev_lt;
      logic [VALUE_W-1:0]  up_val;
      logic [PRIO_W-1:0]   up_pri;
      logic [VALUE_W-1:0]  down_val;
      logic [PRIO_W-1:0]   down_pri;

      assign lt[k] = (CW'(k) < held_ff) && (pri_ff[k] < prio_ff);

      if (k == 0) begin : g_head
         assign prev_lt = 1'b1;
         assign up_val  = item_ff;
         assign up_pri  = prio_ff;
      end else begin : g_body
         assign prev_lt = lt[k-1];
         assign up_val  = val_ff[k-1];
         assign up_pri  = pri_ff[k-1];
      end

      if (k == DEPTH - 1) begin : g_tail
         assign down_val = val_ff[k];
         assign down_pri = pri_ff[k];
      end else begin : g_inner
         assign down_val = val_ff[k+1];
         assign down_pri = pri_ff[k+1];
      end

      always_comb begin
         val_in[k] = val_ff[k];
         pri_in[k] = pri_ff[k];
         priority if (cmd.insert) begin
            if (!lt[k]) begin
               if (prev_lt) begin
                  val_in[k] = item_ff;
                  pri_in[k] = prio_ff;
               end else begin
                  val_in[k] = up_val;
                  pri_in[k] = up_pri;
               end
            end
         end else if (cmd.remove) begin
            val_in[k] = down_val;
            pri_in[k] = down_pri;
         end
      end

      always_ff @(posedge clock) begin
         val_ff[k] <= val_in[k];
         pri_ff[k] <= pri_in[k];
      end
   end

   always_comb begin
      priority if (cmd.insert) begin
         held_in = held_ff + CW'(1);
      end else if (cmd.remove) begin
         held_in = held_ff - CW'(1);
      end else begin
         held_in = held_ff;
      end
   end

   assign removed_in = cmd.remove ? val_ff[0] : '0;
   assign occ_wide   = MW'(held_in);

   always_ff @(posedge clock) begin
      if (reset) begin
         held_ff <= '0;
      end else begin
         held_ff <= held_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.execute) begin
         status_ff  <= cmd.status;
         removed_ff <= removed_in;
         occ_ff     <= occ_wide[OCC_W-1:0];
      end
   end

   assign rsp_status        = status_ff;
   assign rsp_removed_value = removed_ff;
   assign rsp_occupancy     = occ_ff;

   `SPQ_ASSERT(a_count_bound, clock, reset, MW'(held_ff) <= MW'(DEPTH), "count above depth")
   `SPQ_ASSERT(a_insert_room, clock, reset, cmd.insert |-> !stat.full, "insert into full store")
   `SPQ_ASSERT(a_remove_held, clock, reset, cmd.remove |-> (held_ff != '0), "remove from empty store")

endmodule

FILE: rtl/core/sorted_priority_queue_core.sv
// Channel   Handshake           Payload
// request   start / busy        req_op, req_item_value, req_priority_req
// result    rsp_strobe          rsp_status, rsp_removed_value, rsp_occupancy
// csr       csr_we              csr_wdata (capacity)
//
// An item is captured in one cycle and executed in the next, so busy is high
// for one cycle, while the controller is in its execute step. All entry cells
// compare and shift in the execute cycle. The result is strobed for one cycle
// after execute, and a new item may start in that same cycle; the receiver
// cannot hold results off.
// Reset is synchronous and empties the queue with capacity back at 16.
//
// Top level of the sorted priority queue; depends on spq_pkg, spq_ctrl
// and spq_datapath.
`timescale 1ns / 1ps

module sorted_priority_queue_core #(
   parameter int DEPTH = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic                          req_op,
   input  logic [spq_pkg::VALUE_W-1:0]   req_item_value,
   input  logic [spq_pkg::PRIO_W-1:0]    req_priority_req,
   output logic                          rsp_strobe,
   output logic [spq_pkg::STATUS_W-1:0]  rsp_status,
   output logic [spq_pkg::VALUE_W-1:0]   rsp_removed_value,
   output logic [spq_pkg::OCC_W-1:0]     rsp_occupancy,
   input  logic                          csr_we,
   input  logic [spq_pkg::CAP_W-1:0]     csr_wdata
);
   import spq_pkg::*;

   cmd_type  cmd;
   stat_type stat;

   spq_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .rsp_strobe (rsp_strobe),
      .cmd        (cmd),
      .stat       (stat)
   );

   spq_datapath #(
      .DEPTH (DEPTH)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .csr_we            (csr_we),
      .csr_wdata         (csr_wdata),
      .req_op            (req_op),
      .req_item_value    (req_item_value),
      .req_priority_req  (req_priority_req),
      .cmd               (cmd),
      .stat              (stat),
      .rsp_status        (rsp_status),
      .rsp_removed_value (rsp_removed_value),
      .rsp_occupancy     (rsp_occupancy)
   );

endmodule

FILE: test/sorted_priority_queue_core_tb.sv
// Self-checking testbench for sorted_priority_queue_core: directed and random enqueue and
// dequeue items checked against a shadow sorted store, across several capacity settings.
// Depends on spq_pkg and the sorted_priority_queue_core RTL.
`timescale 1ns / 1ps

module sorted_priority_queue_core_tb;
   import spq_pkg::*;

   localparam int DEPTH = 16;
   localparam int PHASE_ITEMS = 200;

   typedef struct packed {
      logic              op;
      logic [VALUE_W-1:0] value;
      logic [PRIO_W-1:0]  prio;
   } queue_op_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [VALUE_W-1:0]  removed;
      logic [OCC_W-1:0]    occupancy;
   } queue_reply_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic req_op = OP_ENQUEUE;
   logic [VALUE_W-1:0] req_item_value = '0;
   logic [PRIO_W-1:0] req_priority_req = '0;
   logic rsp_strobe;
   logic [STATUS_W-1:0] rsp_status;
   logic [VALUE_W-1:0] rsp_removed_value;
   logic [OCC_W-1:0] rsp_occupancy;
   logic csr_we = 1'b0;
   logic [CAP_W-1:0] csr_wdata = '0;

   queue_op_type op_backlog[$];
   queue_reply_type awaited_replies[$];
   queue_op_type next_op;
   int send_gap_pct = 0;
   int fail_count = 0;

   logic [VALUE_W-1:0] shadow_val[DEPTH];
   logic [PRIO_W-1:0] shadow_prio[DEPTH];
   int shadow_held = 0;
   logic [CAP_W-1:0] cap_shadow = CAP_RESET;

   sorted_priority_queue_core #(.DEPTH(DEPTH)) dut (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_op(req_op),
      .req_item_value(req_item_value),
      .req_priority_req(req_priority_req),
      .rsp_strobe(rsp_strobe),
      .rsp_status(rsp_status),
      .rsp_removed_value(rsp_removed_value),
      .rsp_occupancy(rsp_occupancy),
      .csr_we(csr_we),
      .csr_wdata(csr_wdata)
   );

   always #1 clock = ~clock;

   function automatic void shadow_apply_op(logic op, logic [VALUE_W-1:0] v,
                                           logic [PRIO_W-1:0] p);
      queue_reply_type r;
      int lim;
      int pos;
      lim = (int'(cap_shadow) > DEPTH) ? DEPTH : int'(cap_shadow);
      r.status = STAT_DONE;
      r.removed = '0;
      if (op == OP_ENQUEUE) begin
         if (shadow_held >= lim) begin
            r.status = STAT_FULL;
         end else begin
            pos = 0;
            while (pos < shadow_held && shadow_prio[pos] < p) pos++;
            for (int k = shadow_held; k > pos; k--) begin
               shadow_val[k] = shadow_val[k-1];
               shadow_prio[k] = shadow_prio[k-1];
            end
            shadow_val[pos] = v;
            shadow_prio[pos] = p;
            shadow_held++;
         end
      end else begin
         if (shadow_held == 0) begin
            r.status = STAT_EMPTY;
         end else begin
            r.removed = shadow_val[0];
            for (int k = 1; k < shadow_held; k++) begin
               shadow_val[k-1] = shadow_val[k];
               shadow_prio[k-1] = shadow_prio[k];
            end
            shadow_held--;
         end
      end
      r.occupancy = shadow_held[OCC_W-1:0];
      awaited_replies.push_back(r);
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else begin
         if (start && !busy) shadow_apply_op(req_op, req_item_value, req_priority_req);
         if (!start || !busy) begin
            if (op_backlog.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
               next_op = op_backlog.pop_front();
               start <= 1'b1;
               req_op <= next_op.op;
               req_item_value <= next_op.value;
               req_priority_req <= next_op.prio;
            end else begin
               start <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_strobe) begin
         if (awaited_replies.size() == 0) begin
            fail_count++;
            if (fail_count <= 10)
               $display("unexpected result: status %0d removed %h occupancy %0d",
                        rsp_status, rsp_removed_value, rsp_occupancy);
         end else begin
            queue_reply_type want;
            want = awaited_replies.pop_front();
            if (rsp_status !== want.status || rsp_removed_value !== want.removed ||
                rsp_occupancy !== want.occupancy) begin
               fail_count++;
               if (fail_count <= 10)
                  $display({"mismatch: expected status %0d removed %h occupancy %0d, ",
                            "got status %0d removed %h occupancy %0d"},
                           want.status, want.removed, want.occupancy,
                           rsp_status, rsp_removed_value, rsp_occupancy);
            end
         end
      end
   end

   task automatic push_op(logic op, logic [VALUE_W-1:0] v, logic [PRIO_W-1:0] p);
      queue_op_type q;
      q.op = op;
      q.value = v;
      q.prio = p;
      op_backlog.push_back(q);
   endtask

   task automatic wait_quiet();
      do @(negedge clock);
      while (op_backlog.size() != 0 || start || awaited_replies.size() != 0);
   endtask

   task automatic write_capacity(logic [CAP_W-1:0] cap);
      wait_quiet();
      @(posedge clock);
      csr_we <= 1'b1;
      csr_wdata <= cap;
      @(posedge clock);
      csr_we <= 1'b0;
      cap_shadow = cap;
      @(negedge clock);
   endtask

   initial begin : stimulus
      logic [CAP_W-1:0] phase_cap[8];
      int phase_gap[8];
      int burst_left;
      int enq_pct;
      int prio_span;
      phase_cap = '{5'd16, 5'd31, 5'd1, 5'd16, 5'd3, 5'd0, 5'd17, 5'd16};
      phase_gap = '{0, 68, 19, 0, 68, 19, 0, 68};
      phase_cap[7] = CAP_W'($urandom_range(1, DEPTH));
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Reset capacity, then 2 and 0: empty dequeues, extremes, newest-first ties, full stores.
      push_op(OP_DEQUEUE, 16'h0000, 8'h00);
      push_op(OP_ENQUEUE, 16'hFFFF, 8'hFF);
      push_op(OP_ENQUEUE, 16'h0000, 8'h00);
      push_op(OP_ENQUEUE, 16'h1111, 8'h00);
      push_op(OP_ENQUEUE, 16'h2222, 8'h80);
      push_op(OP_ENQUEUE, 16'h3333, 8'h80);
      repeat (5) push_op(OP_DEQUEUE, 16'hFFFF, 8'hFF);
      push_op(OP_DEQUEUE, 16'hFFFF, 8'hFF);
      write_capacity(5'd2);
      push_op(OP_ENQUEUE, 16'hAAAA, 8'h05);
      push_op(OP_ENQUEUE, 16'h5555, 8'h03);
      push_op(OP_ENQUEUE, 16'h0F0F, 8'h01);
      repeat (3) push_op(OP_DEQUEUE, 16'h0000, 8'h00);
      write_capacity(5'd0);
      push_op(OP_ENQUEUE, 16'h1234, 8'h10);
      push_op(OP_DEQUEUE, 16'h0000, 8'h00);

      for (int ph = 0; ph < 8; ph++) begin
         write_capacity(phase_cap[ph]);
         send_gap_pct = phase_gap[ph];
         prio_span = ($urandom_range(1) != 0) ? 3 : 255;
         burst_left = 0;
         enq_pct = 50;
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            if (burst_left == 0) begin
               burst_left = $urandom_range(1, 24);
               case ($urandom_range(2))
                  0: enq_pct = 85;
                  1: enq_pct = 15;
                  default: enq_pct = 55;
               endcase
            end
            burst_left--;
            if (ph == 3 && n >= PHASE_ITEMS - DEPTH) enq_pct = 100;
            push_op(($urandom_range(99) < enq_pct) ? OP_ENQUEUE : OP_DEQUEUE,
                    VALUE_W'($urandom),
                    ($urandom_range(1) != 0) ? PRIO_W'($urandom)
                                             : PRIO_W'($urandom_range(prio_span)));
         end
      end

      wait_quiet();
      repeat (8) @(negedge clock);
      if (fail_count == 0 && awaited_replies.size() == 0) begin
         $display("PASS sorted_priority_queue_core");
      end else begin
         $display("FAIL sorted_priority_queue_core");
      end
      $finish;
   end

   initial begin
      #400000;
      $display("FAIL sorted_priority_queue_core");
      $finish;
   end

endmodule

FILE: files.f
+incdir+rtl/core
rtl/core/spq_pkg.sv
rtl/core/spq_ctrl.sv
rtl/core/spq_datapath.sv
rtl/core/sorted_priority_queue_core.sv
test/sorted_priority_queue_core_tb.sv
